FILE: hdl/isc_pkg.sv
// shared constants, types and tables for the icosahedral section classifier
// Q2.16 matrix constants, umbrella tables and the near-zero test; no dependencies
package isc_pkg;

  localparam int VW  = 24;                       // vector component width
  localparam int SW  = VW + 19;                  // width of a transformed coordinate
  localparam int TDW = ((3 * VW + 7) / 8) * 8;   // slave tdata width
  localparam int CW  = 18;                       // coefficient width

  typedef logic signed [CW-1:0] coef_t;
  typedef logic signed [SW-1:0] acc_t;
  typedef acc_t                 prods_t [5][3];
  typedef logic [4:0]           tri_t;

  localparam coef_t KP = 18'sd20252;
  localparam coef_t KQ = 18'sd12516;
  localparam coef_t KR = 18'sd40503;
  localparam coef_t KH = 18'sd32768;
  localparam coef_t KU = 18'sd65536;

  localparam tri_t T_TOP = 5'd0;
  localparam tri_t T_BOT = 5'd10;

  typedef enum logic [2:0] {
    BR_EQ = 3'b001,
    BR_UP = 3'b010,
    BR_DN = 3'b100
  } branch_e;

  localparam coef_t INV [10][3][3] = '{
    '{'{-KP,  KH,  KQ}, '{'0,  '0, -KR}, '{-KP, -KH,  KQ}},
    '{'{-KQ,  KP, -KH}, '{-KH, -KQ,  KP}, '{ KP, -KH, -KQ}},
    '{'{-KR,  '0, '0}, '{ KQ, -KP, -KH}, '{ KQ, -KP,  KH}},
    '{'{-KH,  KQ, -KP}, '{'0, -KR,  '0}, '{ KH,  KQ, -KP}},
    '{'{-KQ, -KP, -KH}, '{-KQ, -KP,  KH}, '{ KR,  '0, '0}},
    '{'{-KP, -KH, -KQ}, '{ KQ,  KP, -KH}, '{ KH, -KQ,  KP}},
    '{'{ KP, -KH,  KQ}, '{'0,  '0, -KR}, '{ KP,  KH,  KQ}},
    '{'{ KQ, -KP, -KH}, '{ KH,  KQ,  KP}, '{-KP,  KH, -KQ}},
    '{'{ KH, -KQ, -KP}, '{'0,  KR,  '0}, '{-KH, -KQ, -KP}},
    '{'{ KP,  KH, -KQ}, '{-KH,  KQ,  KP}, '{-KQ, -KP, -KH}}
  };

  localparam coef_t MID [10][3][3] = '{
    '{'{'0,  KU, -KR}, '{'0, -KU, -KR}, '{-KR, '0,  KU}},
    '{'{-KU, KR, '0}, '{'0, -KU,  KR}, '{ KR, '0, -KU}},
    '{'{-KR, '0, -KU}, '{ KU, -KR, '0}, '{-KR, '0,  KU}},
    '{'{-KU, -KR, '0}, '{ KU, -KR, '0}, '{'0,  KU, -KR}},
    '{'{-KU, -KR, '0}, '{ KR, '0,  KU}, '{ KR, '0, -KU}},
    '{'{-KR, '0, -KU}, '{ KU,  KR, '0}, '{'0, -KU,  KR}},
    '{'{'0, -KU, -KR}, '{'0,  KU, -KR}, '{ KR, '0,  KU}},
    '{'{ KU, -KR, '0}, '{'0,  KU,  KR}, '{-KR, '0, -KU}},
    '{'{ KU,  KR, '0}, '{-KU,  KR, '0}, '{'0, -KU, -KR}},
    '{'{'0,  KU,  KR}, '{-KU, -KR, '0}, '{ KR, '0, -KU}}
  };

  localparam tri_t UMB_COMP [3][5] = '{
    '{5'd9,  5'd8,  5'd7,  5'd12, 5'd14},
    '{5'd1,  5'd2,  5'd4,  5'd5,  5'd3},
    '{5'd16, 5'd15, 5'd13, 5'd18, 5'd17}
  };

  // row picks: equal-branch a, up-branch a/b, down-branch a/b
  localparam logic [1:0] UMB_SEL [3][5] = '{
    '{2'd1, 2'd2, 2'd0, 2'd0, 2'd2},
    '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0},
    '{2'd2, 2'd2, 2'd0, 2'd2, 2'd1}
  };

  function automatic logic near0(acc_t a, logic [15:0] tol);
    acc_t mag;
    mag = a[SW-1] ? -a : a;
    return mag <= acc_t'({{(SW-16){1'b0}}, tol});
  endfunction

  function automatic tri_t flip(tri_t c);
    return (c < 5'd10) ? c + 5'd10 : c - 5'd10;
  endfunction

  function automatic logic [3:0] base_tri(tri_t c);
    tri_t m;
    m = (c < 5'd10) ? c : c - 5'd10;
    return m[3:0];
  endfunction

endpackage

FILE: hdl/isc_row_sum.sv
// one matrix row applied to the stored constant products of a vector
// depends on isc_pkg for the coefficient constants and product types
module isc_row_sum import isc_pkg::*; (
  input  prods_t prods_i,
  input  coef_t  coef_i [3],
  input  logic   neg_i,
  output acc_t   sum_o
);

  acc_t term [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      case (coef_i[j])
        KP:      term[j] = prods_i[0][j];
        -KP:     term[j] = -prods_i[0][j];
        KQ:      term[j] = prods_i[1][j];
        -KQ:     term[j] = -prods_i[1][j];
        KR:      term[j] = prods_i[2][j];
        -KR:     term[j] = -prods_i[2][j];
        KH:      term[j] = prods_i[3][j];
        -KH:     term[j] = -prods_i[3][j];
        KU:      term[j] = prods_i[4][j];
        -KU:     term[j] = -prods_i[4][j];
        default: term[j] = '0;
      endcase
      if (neg_i) begin
        term[j] = -term[j];
      end
    end
  end

  assign sum_o = term[0] + term[1] + term[2];

endmodule

FILE: hdl/icosahedral_section_classifier.sv
// top level of the icosahedral section classifier: eight-stage pipeline
// depends on isc_pkg and isc_row_sum
//
// usage:
//   slave stream carries one vector per request: tdata holds vec_x, vec_y,
//   vec_z (24 bits each, two's complement), tuser holds include_boundary.
//   master stream returns one result per request: tdata[6:0] is the section
//   index (4 * triangle + subtriangle), tuser is no_section.
//   cfg channel writes the 16-bit zero tolerance (reset value 16); it is
//   always ready and should be written while the pipeline is empty.
// throughput: one request per cycle while the master side takes results;
//   the stages are constant products, the triangle-0 transform, sign
//   classification, umbrella compare, neighbor transform, triangle pick,
//   middle transform and subtriangle pick.
// reset clears all stage valid bits; the tolerance returns to 16.
// a stalled master side freezes the whole pipeline and holds the result;
//   tready on the slave side drops in the same cycle.
module icosahedral_section_classifier import isc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [TDW-1:0] s_axis_tdata,   // vec_x, vec_y, vec_z
  input  logic           s_axis_tuser,   // include_boundary
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,   // section_index, zero pad
  output logic           m_axis_tuser,   // no_section
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);

  logic        en;
  logic [15:0] tol_q;
  logic [7:1]  vld_q;
  logic [7:1]  incl_q;

  prods_t p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  prods_t p1_d;

  acc_t w2_d [3];
  acc_t w2_q [3];

  // stage 3 classification
  logic [1:0] npos, nneg;
  logic [2:0] n3, s3;
  logic       done3_d, done3_q, tok3_d, tok3_q, hi3_d, hi3_q;
  tri_t       t3_d, t3_q;
  logic [1:0] umb3_d, umb3_q;
  acc_t       ua3_d, ub3_d, ua3_q, ub3_q;

  // stage 4 umbrella compare
  acc_t       diff4;
  branch_e    br4_d, br4_q;
  tri_t       uc4_d [5];
  tri_t       uc4_q [5];
  tri_t       c4_d, c4_q;
  logic [1:0] ra4_d, rb4_d, ra4_q, rb4_q;
  logic       lt4_q, done4_q, tok4_q;
  tri_t       t4_q;

  // stage 5 neighbor transform
  coef_t      ca5 [3];
  coef_t      cb5 [3];
  acc_t       a5_d, b5_d, a5_q, b5_q;
  branch_e    br5_q;
  tri_t       uc5_q [5];
  tri_t       c5_q, t5_q;
  logic       lt5_q, done5_q, tok5_q;

  // stage 6 triangle pick
  logic       na6, nb6, tok6_d, tok6_q;
  tri_t       t6_d, t6_q;

  // stage 7 middle transform
  coef_t      cm7 [3][3];
  acc_t       m7_d [3];
  acc_t       m7_q [3];
  logic       tok7_q;
  tri_t       t7_q;

  // output
  logic [2:0] nm8;
  logic       nos8_d, out_vld_q, nos_q;
  logic [1:0] sub8;
  logic [6:0] sec8_d, sec_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 16'd16;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // stage 1: constant products of each component
  always_comb begin
    acc_t ve;
    for (int j = 0; j < 3; j++) begin
      ve = acc_t'($signed(s_axis_tdata[j*VW +: VW]));
      p1_d[0][j] = ve * acc_t'(KP);
      p1_d[1][j] = ve * acc_t'(KQ);
      p1_d[2][j] = ve * acc_t'(KR);
      p1_d[3][j] = ve * acc_t'(KH);
      p1_d[4][j] = ve * acc_t'(KU);
    end
  end

  // stage 2: triangle-0 inverse
  for (genvar r = 0; r < 3; r++) begin : g_w2
    isc_row_sum u_row (
      .prods_i (p1_q),
      .coef_i  (INV[0][r]),
      .neg_i   (1'b0),
      .sum_o   (w2_d[r])
    );
  end

  // stage 3: sign classes and umbrella choice
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n3[i] = near0(w2_q[i], tol_q);
      s3[i] = w2_q[i][SW-1];
    end
    npos = 2'(32'(!n3[0] && !s3[0]) + 32'(!n3[1] && !s3[1]) + 32'(!n3[2] && !s3[2]));
    nneg = 2'(32'(!n3[0] && s3[0]) + 32'(!n3[1] && s3[1]) + 32'(!n3[2] && s3[2]));
    done3_d = 1'b1;
    tok3_d  = incl_q[2];
    t3_d    = T_TOP;
    hi3_d   = 1'b0;
    umb3_d  = 2'd0;
    if (npos == 2'd3) begin
      tok3_d = 1'b1;
    end else if (nneg == 2'd3) begin
      tok3_d = 1'b1;
      t3_d   = T_BOT;
    end else if (nneg == 2'd0 && npos != 2'd0) begin
      t3_d = T_TOP;
    end else if (npos == 2'd0 && nneg != 2'd0) begin
      t3_d = T_BOT;
    end else if (npos == 2'd0 && nneg == 2'd0) begin
      tok3_d = 1'b0;
    end else if (npos == 2'd1 && nneg == 2'd2) begin
      done3_d = 1'b0;
      hi3_d   = 1'b1;
      umb3_d  = (!n3[0] && !s3[0]) ? 2'd1 : (!n3[1] && !s3[1]) ? 2'd2 : 2'd0;
    end else begin
      done3_d = 1'b0;
      umb3_d  = (!n3[0] && s3[0]) ? 2'd1 : (!n3[1] && s3[1]) ? 2'd2 : 2'd0;
    end
    case (umb3_d)
      2'd0:    begin ua3_d = w2_q[0]; ub3_d = w2_q[1]; end
      2'd1:    begin ua3_d = w2_q[1]; ub3_d = w2_q[2]; end
      default: begin ua3_d = w2_q[2]; ub3_d = w2_q[0]; end
    endcase
  end

  // stage 4: umbrella coefficient compare
  always_comb begin
    diff4 = hi3_q ? ub3_q - ua3_q : ua3_q - ub3_q;
    if (near0(diff4, tol_q)) begin
      br4_d = BR_EQ;
    end else if (diff4[SW-1]) begin
      br4_d = BR_UP;
    end else begin
      br4_d = BR_DN;
    end
    for (int k = 0; k < 5; k++) begin
      uc4_d[k] = hi3_q ? flip(UMB_COMP[umb3_q][k]) : UMB_COMP[umb3_q][k];
    end
    case (br4_d)
      BR_EQ: begin
        c4_d  = uc4_d[0];
        ra4_d = UMB_SEL[umb3_q][0];
        rb4_d = UMB_SEL[umb3_q][0];
      end
      BR_UP: begin
        c4_d  = uc4_d[1];
        ra4_d = UMB_SEL[umb3_q][1];
        rb4_d = UMB_SEL[umb3_q][2];
      end
      default: begin
        c4_d  = uc4_d[4];
        ra4_d = UMB_SEL[umb3_q][3];
        rb4_d = UMB_SEL[umb3_q][4];
      end
    endcase
  end

  // stage 5: transform into the candidate neighbor triangle
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ca5[j] = INV[base_tri(c4_q)][ra4_q][j];
      cb5[j] = INV[base_tri(c4_q)][rb4_q][j];
    end
  end

  isc_row_sum u_row_a (
    .prods_i (p4_q),
    .coef_i  (ca5),
    .neg_i   (c4_q > 5'd9),
    .sum_o   (a5_d)
  );

  isc_row_sum u_row_b (
    .prods_i (p4_q),
    .coef_i  (cb5),
    .neg_i   (c4_q > 5'd9),
    .sum_o   (b5_d)
  );

  // stage 6: triangle decision
  always_comb begin
    na6    = near0(a5_q, tol_q);
    nb6    = near0(b5_q, tol_q);
    tok6_d = 1'b1;
    t6_d   = c5_q;
    if (done5_q) begin
      tok6_d = tok5_q;
      t6_d   = t5_q;
    end else begin
      case (br5_q)
        BR_EQ: begin
          if (na6) begin
            tok6_d = incl_q[5];
          end else if (a5_q[SW-1]) begin
            tok6_d = incl_q[5];
            t6_d   = lt5_q ? uc5_q[3] : uc5_q[2];
          end
        end
        BR_UP: begin
          if (na6) begin
            tok6_d = incl_q[5];
            t6_d   = a5_q[SW-1] ? uc5_q[2] : uc5_q[1];
          end else if (a5_q[SW-1]) begin
            t6_d = uc5_q[2];
          end else if (nb6) begin
            tok6_d = incl_q[5];
            t6_d   = (!b5_q[SW-1] && b5_q != '0) ? uc5_q[1] : uc5_q[0];
          end else if (b5_q[SW-1]) begin
            t6_d = uc5_q[0];
          end
        end
        default: begin
          if (na6) begin
            tok6_d = incl_q[5];
            t6_d   = a5_q[SW-1] ? uc5_q[0] : uc5_q[4];
          end else if (a5_q[SW-1]) begin
            t6_d = uc5_q[0];
          end else if (nb6) begin
            tok6_d = incl_q[5];
            t6_d   = (!b5_q[SW-1] && b5_q != '0) ? uc5_q[4] : uc5_q[3];
          end else if (b5_q[SW-1]) begin
            t6_d = uc5_q[3];
          end
        end
      endcase
    end
  end

  // stage 7: middle-triangle inverse
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        cm7[r][j] = MID[base_tri(t6_q)][r][j];
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_m7
    isc_row_sum u_row (
      .prods_i (p6_q),
      .coef_i  (cm7[r]),
      .neg_i   (t6_q > 5'd9),
      .sum_o   (m7_d[r])
    );
  end

  // stage 8: subtriangle decision
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nm8[i] = near0(m7_q[i], tol_q);
    end
    nos8_d = !tok7_q || ((nm8 != 3'b000) && !incl_q[7]);
    if (!nm8[0] && m7_q[0][SW-1]) begin
      sub8 = 2'd3;
    end else if (!nm8[1] && m7_q[1][SW-1]) begin
      sub8 = 2'd1;
    end else if (!nm8[2] && m7_q[2][SW-1]) begin
      sub8 = 2'd2;
    end else begin
      sub8 = 2'd0;
    end
    sec8_d = nos8_d ? 7'd0 : {t7_q, sub8};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[6:1], s_axis_tvalid};
      out_vld_q <= vld_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      incl_q  <= {incl_q[6:1], s_axis_tuser};
      p1_q    <= p1_d;
      p2_q    <= p1_q;
      p3_q    <= p2_q;
      p4_q    <= p3_q;
      p5_q    <= p4_q;
      p6_q    <= p5_q;
      w2_q    <= w2_d;
      done3_q <= done3_d;
      tok3_q  <= tok3_d;
      t3_q    <= t3_d;
      hi3_q   <= hi3_d;
      umb3_q  <= umb3_d;
      ua3_q   <= ua3_d;
      ub3_q   <= ub3_d;
      br4_q   <= br4_d;
      uc4_q   <= uc4_d;
      c4_q    <= c4_d;
      ra4_q   <= ra4_d;
      rb4_q   <= rb4_d;
      lt4_q   <= diff4[SW-1];
      done4_q <= done3_q;
      tok4_q  <= tok3_q;
      t4_q    <= t3_q;
      a5_q    <= a5_d;
      b5_q    <= b5_d;
      br5_q   <= br4_q;
      uc5_q   <= uc4_q;
      c5_q    <= c4_q;
      lt5_q   <= lt4_q;
      done5_q <= done4_q;
      tok5_q  <= tok4_q;
      t5_q    <= t4_q;
      tok6_q  <= tok6_d;
      t6_q    <= t6_d;
      m7_q    <= m7_d;
      tok7_q  <= tok6_q;
      t7_q    <= t6_q;
      nos_q   <= nos8_d;
      sec_q   <= sec8_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, sec_q};
  assign m_axis_tuser  = nos_q;

  a_nosec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[6:0] == 7'd0)
    else $error("rejected result carries a nonzero section");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[6:0] < 7'd80)
    else $error("section index out of range");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[1])
    else $error("accepted request did not enter the pipeline");

endmodule

FILE: test/testbench.sv
// stream testbench for icosahedral_section_classifier: random and directed vectors
// checked against a local predictor of the section lookup; depends on isc_pkg
`timescale 1ns / 1ps

module testbench;
  import isc_pkg::*;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        incl;
  } vec_req_t;

  typedef struct packed {
    logic [6:0] section;
    logic       none;
  } section_t;

  localparam int WATCHDOG = 20000;
  localparam longint PK = 20252, QK = 12516, RK = 40503, HK = 32768, UK = 65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDW-1:0] s_axis_tdata = '0;   // vec_x, vec_y, vec_z
  logic s_axis_tuser = 1'b0;           // include_boundary
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // section_index, zero pad
  logic m_axis_tuser;                  // no_section
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  icosahedral_section_classifier DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  vec_req_t pending_vecs[$];
  section_t expected_sections[$];
  logic [15:0] tol_model = 16;
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int send_wait = 0, recv_wait = 0;
  int hold_off = 0;
  int boundary_hits = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  // local copies of the transform tables
  longint inv_m [10][3][3] = '{
    '{'{-PK, HK, QK}, '{0, 0, -RK}, '{-PK, -HK, QK}},
    '{'{-QK, PK, -HK}, '{-HK, -QK, PK}, '{PK, -HK, -QK}},
    '{'{-RK, 0, 0}, '{QK, -PK, -HK}, '{QK, -PK, HK}},
    '{'{-HK, QK, -PK}, '{0, -RK, 0}, '{HK, QK, -PK}},
    '{'{-QK, -PK, -HK}, '{-QK, -PK, HK}, '{RK, 0, 0}},
    '{'{-PK, -HK, -QK}, '{QK, PK, -HK}, '{HK, -QK, PK}},
    '{'{PK, -HK, QK}, '{0, 0, -RK}, '{PK, HK, QK}},
    '{'{QK, -PK, -HK}, '{HK, QK, PK}, '{-PK, HK, -QK}},
    '{'{HK, -QK, -PK}, '{0, RK, 0}, '{-HK, -QK, -PK}},
    '{'{PK, HK, -QK}, '{-HK, QK, PK}, '{-QK, -PK, -HK}}};
  longint mid_m [10][3][3] = '{
    '{'{0, UK, -RK}, '{0, -UK, -RK}, '{-RK, 0, UK}},
    '{'{-UK, RK, 0}, '{0, -UK, RK}, '{RK, 0, -UK}},
    '{'{-RK, 0, -UK}, '{UK, -RK, 0}, '{-RK, 0, UK}},
    '{'{-UK, -RK, 0}, '{UK, -RK, 0}, '{0, UK, -RK}},
    '{'{-UK, -RK, 0}, '{RK, 0, UK}, '{RK, 0, -UK}},
    '{'{-RK, 0, -UK}, '{UK, RK, 0}, '{0, -UK, RK}},
    '{'{0, -UK, -RK}, '{0, UK, -RK}, '{RK, 0, UK}},
    '{'{UK, -RK, 0}, '{0, UK, RK}, '{-RK, 0, -UK}},
    '{'{UK, RK, 0}, '{-UK, RK, 0}, '{0, -UK, -RK}},
    '{'{0, UK, RK}, '{-UK, -RK, 0}, '{RK, 0, -UK}}};
  int fan_tri [3][5] = '{'{9, 8, 7, 12, 14}, '{1, 2, 4, 5, 3}, '{16, 15, 13, 18, 17}};
  int fan_pick [3][5] = '{'{1, 2, 0, 0, 2}, '{0, 0, 2, 2, 0}, '{2, 2, 0, 2, 1}};

  function automatic bit is_zero(longint a);
    return (a < 0 ? -a : a) <= longint'(tol_model);
  endfunction

  function automatic void transform(longint m[3][3], longint v[3], bit neg,
                                    output longint w[3]);
    longint s;
    for (int i = 0; i < 3; i++) begin
      s = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
      w[i] = neg ? -s : s;
    end
  endfunction

  function automatic int fan_member(int fan, int k);
    int c;
    c = fan_tri[fan % 3][k];
    return fan < 3 ? c : (c + 10) % 20;
  endfunction

  function automatic int fan_search(int fan, longint v[3], longint u[3], bit incl);
    longint w[3];
    longint a, b;
    int c, r;
    r = fan % 3;
    if (is_zero(u[0] - u[1])) begin
      c = fan_member(fan, 0);
      transform(inv_m[c % 10], v, c > 9, w);
      a = w[fan_pick[r][0]];
      if (is_zero(a)) return incl ? c : -1;
      if (a < 0) return incl ? fan_member(fan, u[0] < u[1] ? 3 : 2) : -1;
      return c;
    end
    if (u[1] > u[0]) begin
      c = fan_member(fan, 1);
      transform(inv_m[c % 10], v, c > 9, w);
      a = w[fan_pick[r][1]];
      b = w[fan_pick[r][2]];
      if (is_zero(a)) return incl ? fan_member(fan, a < 0 ? 2 : 1) : -1;
      if (a < 0) return fan_member(fan, 2);
      if (is_zero(b)) return incl ? fan_member(fan, b > 0 ? 1 : 0) : -1;
      if (b < 0) return fan_member(fan, 0);
      return c;
    end
    c = fan_member(fan, 4);
    transform(inv_m[c % 10], v, c > 9, w);
    a = w[fan_pick[r][3]];
    b = w[fan_pick[r][4]];
    if (is_zero(a)) return incl ? fan_member(fan, a < 0 ? 0 : 4) : -1;
    if (a < 0) return fan_member(fan, 0);
    if (is_zero(b)) return incl ? fan_member(fan, b > 0 ? 4 : 3) : -1;
    if (b < 0) return fan_member(fan, 3);
    return c;
  endfunction

  function automatic int triangle_of(longint v[3], bit incl);
    longint w[3], u[3];
    int zc, bal, fan;
    zc = 0;
    bal = 0;
    transform(inv_m[0], v, 1'b0, w);
    for (int i = 0; i < 3; i++) begin
      if (is_zero(w[i])) zc++;
      else if (w[i] > 0) bal++;
      else bal--;
    end
    case (bal)
      3: return 0;
      -3: return 10;
      2: return incl ? 0 : -1;
      -2: return incl ? 10 : -1;
      1: begin
        if (zc == 2) return incl ? 0 : -1;
        fan = (!is_zero(w[0]) && w[0] < 0) ? 1 : (!is_zero(w[1]) && w[1] < 0) ? 2 : 0;
      end
      -1: begin
        if (zc == 2) return incl ? 10 : -1;
        fan = (!is_zero(w[0]) && w[0] > 0) ? 4 : (!is_zero(w[1]) && w[1] > 0) ? 5 : 3;
        for (int i = 0; i < 3; i++) w[i] = -w[i];
      end
      default: begin
        if (zc == 3) return -1;
        fan = (!is_zero(w[0]) && w[0] < 0) ? 1 : (!is_zero(w[1]) && w[1] < 0) ? 2 : 0;
      end
    endcase
    case (fan % 3)
      0: begin u[0] = w[0]; u[1] = w[1]; u[2] = -w[2]; end
      1: begin u[0] = w[1]; u[1] = w[2]; u[2] = -w[0]; end
      default: begin u[0] = w[2]; u[1] = w[0]; u[2] = -w[1]; end
    endcase
    return fan_search(fan, v, u, incl);
  endfunction

  function automatic section_t classify(vec_req_t r);
    longint v[3], w[3];
    int t, s;
    section_t res;
    v[0] = longint'($signed(r.x));
    v[1] = longint'($signed(r.y));
    v[2] = longint'($signed(r.z));
    t = triangle_of(v, r.incl);
    s = -1;
    if (t >= 0) begin
      transform(mid_m[t % 10], v, t > 9, w);
      if ((is_zero(w[0]) || is_zero(w[1]) || is_zero(w[2])) && !r.incl) s = -1;
      else if (!is_zero(w[0]) && w[0] < 0) s = 3;
      else if (!is_zero(w[1]) && w[1] < 0) s = 1;
      else if (!is_zero(w[2]) && w[2] < 0) s = 2;
      else s = 0;
    end
    res.none = (s < 0);
    res.section = (s < 0) ? 7'd0 : 7'(4 * t + s);
    return res;
  endfunction

  // handshakes as seen at the rising edge
  always @(posedge clk_i) begin
    in_taken  <= s_axis_tvalid && s_axis_tready;
    out_taken <= m_axis_tvalid && m_axis_tready;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        expected_sections.push_back(classify({s_axis_tdata[23:0], s_axis_tdata[47:24],
                                              s_axis_tdata[71:48], s_axis_tuser}));
        void'(pending_vecs.pop_front());
        send_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
      end
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_vecs.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pending_vecs[0].z, pending_vecs[0].y, pending_vecs[0].x};
        s_axis_tuser <= pending_vecs[0].incl;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken)
        recv_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    section_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_sections.size() == 0) begin
        $display("%0t: unexpected result section=%0d none=%0b", $time,
                 m_axis_tdata[6:0], m_axis_tuser);
        errors++;
      end else begin
        want = expected_sections.pop_front();
        if (m_axis_tdata[6:0] !== want.section || m_axis_tuser !== want.none) begin
          $display("%0t: expected section=%0d none=%0b, got section=%0d none=%0b",
                   $time, want.section, want.none, m_axis_tdata[6:0], m_axis_tuser);
          errors++;
        end
        if (want.none) boundary_hits++;
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_valid_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [23:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 24'(int'($urandom_range(0, 40)) - 20);
      1: return 24'h7fffff;
      2: return 24'h800000;
      3: return 24'($urandom_range(0, 4000));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic push_vec(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic incl);
    vec_req_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.incl = incl;
    pending_vecs.push_back(r);
  endtask

  task automatic drain();
    while (pending_vecs.size() > 0 || expected_sections.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tol_model = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_batch(int n);
    int pick;
    longint s;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        // points lying on or near a vertex direction or edge
        s = $urandom_range(1, 300000);
        push_vec(24'(s * ($urandom_range(0, 1) ? 1 : -1)),
                 24'(s * ($urandom_range(0, 1) ? 1 : -1) + int'($urandom_range(0, 6)) - 3),
                 24'(($urandom_range(0, 2) == 0) ? 0 : s),
                 1'($urandom));
      end else begin
        push_vec(rand_comp(), rand_comp(), rand_comp(), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: null vector, extremes, axes, boundary flag both ways
    for (int b = 0; b < 2; b++) begin
      push_vec(24'd0, 24'd0, 24'd0, 1'(b));
      push_vec(24'h7fffff, 24'h7fffff, 24'h7fffff, 1'(b));
      push_vec(24'h800000, 24'h800000, 24'h800000, 1'(b));
      push_vec(24'h7fffff, 24'd0, 24'd0, 1'(b));
      push_vec(24'd0, 24'h800000, 24'd0, 1'(b));
      push_vec(24'd0, 24'd0, 24'h7fffff, 1'(b));
      push_vec(24'd1000, 24'd1000, 24'd0, 1'(b));
      push_vec(24'd1, 24'hffffff, 24'd1, 1'(b));
      push_vec(24'h800000, 24'h7fffff, 24'h000001, 1'(b));
      push_vec(24'd5000, 24'd0, 24'd8090, 1'(b));
    end
    drain();

    write_tolerance(16'd0);
    random_batch(400);
    // long receiver stall while the sender keeps going
    @(negedge clk_i);
    hold_off <= 80;
    drain();

    write_tolerance(16'hffff);
    random_batch(400);
    drain();

    write_tolerance(16'd300);
    random_batch(400);
    drain();

    write_tolerance(16'd16);
    random_batch(480);
    drain();

    $display("covered %0d results, %0d with no section, tolerance 0 to 65535",
             results_seen, boundary_hits);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
